FILE: sv/ahrd_pkg.sv
// ahrd_pkg: shared types, codes and constants of the audio requantizer
// used by ahrd_front, ahrd_queue, ahrd_back and audio_halve_requantize_dither
// no dependencies
`default_nettype none

package ahrd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_WIDE = 2'd1;

	// mode codes; the top code behaves as MODE_BOTH
	localparam logic [1:0] MODE_REDUCE = 2'd0;
	localparam logic [1:0] MODE_HALVE  = 2'd1;
	localparam logic [1:0] MODE_BOTH   = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic signed [19:0] WIDE_OFFSET_HALVE = 20'sd131072;

	// what the back part does with one job
	typedef enum logic [2:0] {
		JOB_PASS,   // narrow input in reduce mode, value passes unchanged
		JOB_R8,     // wide to 8-bit, grid 256
		JOB_H2,     // narrow halve, grid 4
		JOB_H2W,    // wide halve, grid 4, back to signed
		JOB_H10,    // wide halve and reduce, grid 1024
		JOB_CLR     // no result, end of sound only
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic signed [19:0] value;
		logic              last;
	} job_t;

	typedef struct packed {
		logic signed [15:0] sample_in;
		logic               end_of_sound;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               out_last;
	} out_item_t;

	// queue push from the front part
	typedef struct packed {
		logic push;
	} q_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ahrd_front.sv
// ahrd_front: accepts input items, holds configuration and pair state,
// forms the filtered value and the job kind; depends on ahrd_pkg
`default_nettype none

module ahrd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [1:0]       cfg_data,
	input  wire logic             sample_valid,
	output logic                  sample_stall,
	input  wire ahrd_pkg::in_item_t sample_item,
	input  wire logic             q_full,
	output ahrd_pkg::q_ctl_t      q_ctl,
	output ahrd_pkg::job_t        job
);

	logic [1:0]         mode_q;
	logic               wide_q;
	logic signed [16:0] prev_q;
	logic signed [16:0] first_q;
	logic               phase_q;
	logic               start_q;

	logic               accept;
	logic               last;
	logic               reduce;
	logic signed [16:0] s;
	logic signed [19:0] filt;
	logic               push;

	assign sample_stall = q_full;
	assign accept       = sample_valid && !q_full;
	assign last         = sample_item.end_of_sound;
	assign reduce       = (mode_q == ahrd_pkg::MODE_REDUCE);

	always_comb begin
		if (wide_q) begin
			s = {sample_item.sample_in[15], sample_item.sample_in};
		end else begin
			s = {9'd0, sample_item.sample_in[7:0]};
		end
	end

	// p + 2a + b, offset for wide input
	always_comb begin
		filt = {{3{prev_q[16]}}, prev_q} + {{2{first_q[16]}}, first_q, 1'b0}
			+ {{3{s[16]}}, s};
		if (wide_q) begin
			filt = filt + ahrd_pkg::WIDE_OFFSET_HALVE;
		end
	end

	always_comb begin
		job.last  = last;
		job.kind  = ahrd_pkg::JOB_CLR;
		job.value = filt;
		push      = 1'b0;
		if (reduce) begin
			push = 1'b1;
			if (wide_q) begin
				job.kind  = ahrd_pkg::JOB_R8;
				job.value = {4'd0, ~s[15], s[14:0]};
			end else begin
				job.kind  = ahrd_pkg::JOB_PASS;
				job.value = {{3{s[16]}}, s};
			end
		end else if (phase_q) begin
			push = 1'b1;
			if (!wide_q) begin
				job.kind = ahrd_pkg::JOB_H2;
			end else if (mode_q == ahrd_pkg::MODE_HALVE) begin
				job.kind = ahrd_pkg::JOB_H2W;
			end else begin
				job.kind = ahrd_pkg::JOB_H10;
			end
		end else begin
			// unpaired sample: only an end of sound needs the back part
			push = last;
		end
	end

	assign q_ctl.push = accept && push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ahrd_pkg::MODE_REDUCE;
			wide_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == ahrd_pkg::REG_MODE) begin
				mode_q <= cfg_data;
			end else if (cfg_index == ahrd_pkg::REG_WIDE) begin
				wide_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			first_q <= '0;
			phase_q <= 1'b0;
			start_q <= 1'b1;
		end else if (accept) begin
			if (last) begin
				prev_q  <= '0;
				first_q <= '0;
				phase_q <= 1'b0;
				start_q <= 1'b1;
			end else if (!reduce) begin
				if (!phase_q) begin
					if (start_q) begin
						prev_q <= s;
					end
					start_q <= 1'b0;
					first_q <= s;
					phase_q <= 1'b1;
				end else begin
					prev_q  <= s;
					phase_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/ahrd_queue.sv
// ahrd_queue: short job queue between the front and back parts
// depends on ahrd_pkg
`default_nettype none

module ahrd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ahrd_pkg::q_ctl_t q_ctl,
	input  wire ahrd_pkg::job_t   push_job,
	output logic                  full,
	output logic                  nonempty,
	output ahrd_pkg::job_t        head,
	input  wire logic             pop
);

	ahrd_pkg::job_t                 entries_q [ahrd_pkg::QUEUE_DEPTH];
	logic [ahrd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ahrd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ahrd_pkg::QPTR_W:0]      count_q;

	assign full     = (count_q == (ahrd_pkg::QPTR_W+1)'(ahrd_pkg::QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_ctl.push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_ctl.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (q_ctl.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !q_ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/ahrd_back.sv
// ahrd_back: error-diffusion quantizer with the running error and the
// output register; depends on ahrd_pkg
`default_nettype none

module ahrd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_nonempty,
	input  wire ahrd_pkg::job_t head,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output ahrd_pkg::out_item_t result_item
);

	logic signed [31:0] err_q;
	logic               valid_q;
	ahrd_pkg::out_item_t result_q;

	logic [9:0]         half;
	logic [33:0]        grid_mask;
	logic [33:0]        top;
	logic               quantizes;
	logic signed [33:0] orig;
	logic signed [33:0] v;
	logic [33:0]        masked;
	logic [33:0]        q;
	logic signed [34:0] e;
	logic signed [31:0] e_sat;
	logic [15:0]        res;

	assign pop          = q_nonempty && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result_item  = result_q;

	always_comb begin
		quantizes = 1'b1;
		half      = 10'd2;
		grid_mask = 34'h3;
		top       = 34'h3fc;
		case (head.kind)
			ahrd_pkg::JOB_R8: begin
				half      = 10'd127;
				grid_mask = 34'hff;
				top       = 34'hff00;
			end
			ahrd_pkg::JOB_H2: begin
				top = 34'h3fc;
			end
			ahrd_pkg::JOB_H2W: begin
				top = 34'h3fffc;
			end
			ahrd_pkg::JOB_H10: begin
				half      = 10'd512;
				grid_mask = 34'h3ff;
				top       = 34'h3fc00;
			end
			default: begin
				quantizes = 1'b0;
			end
		endcase
	end

	always_comb begin
		orig   = {{2{err_q[31]}}, err_q} + {{14{head.value[19]}}, head.value};
		v      = orig + $signed({24'd0, half});
		masked = v & ~grid_mask;
		if (v[33]) begin
			q = '0;
		end else if (masked > top) begin
			q = top;
		end else begin
			q = masked;
		end
		e = {orig[33], orig} - $signed({1'b0, q});
		if (e > 35'sh0_7fff_ffff) begin
			e_sat = 32'sh7fff_ffff;
		end else if (e < -35'sh0_8000_0000) begin
			e_sat = -32'sh8000_0000;
		end else begin
			e_sat = e[31:0];
		end
	end

	always_comb begin
		case (head.kind)
			ahrd_pkg::JOB_R8:  res = {8'd0, q[15:8]};
			ahrd_pkg::JOB_H2:  res = {8'd0, q[9:2]};
			ahrd_pkg::JOB_H2W: res = q[17:2] ^ 16'h8000;
			ahrd_pkg::JOB_H10: res = {8'd0, q[17:10]};
			default:           res = head.value[15:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				err_q <= '0;
			end else if (quantizes) begin
				err_q <= e_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && head.kind != ahrd_pkg::JOB_CLR) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind != ahrd_pkg::JOB_CLR) begin
			result_q.sample_out <= res;
			result_q.out_last   <= head.last;
		end
	end

endmodule

`default_nettype wire

FILE: sv/audio_halve_requantize_dither.sv
// audio_halve_requantize_dither: top level of the audio requantizer
// instantiates ahrd_front, ahrd_queue and ahrd_back; depends on ahrd_pkg
//
// Samples enter on the sample channel (sample_valid, sample_stall, sample_item)
// and results leave on the result channel (result_valid, result_stall,
// result_item). An item moves at a clock edge with valid high and stall low.
// The front part keeps the pair state and forms a job for every sample that
// gives a result or ends a sound; a two-entry queue feeds the back part, which
// rounds with the running error and holds the result in an output register.
// One sample is taken every cycle while sample_stall is low; the result of a
// sample is written to the queue, then taken into the output register.
// In halve modes the first sample of a pair gives no result.
// When result_stall is high the output register holds, the queue fills and
// then sample_stall rises; no item is lost.
// Reset clears the pair state, the error, the queue and the output valid,
// and sets mode 0 with wide input. cfg_we writes register cfg_index
// (0 mode, 1 input_is_wide) from cfg_data; write only while idle.
`default_nettype none

module audio_halve_requantize_dither (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [1:0]          cfg_data,
	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire ahrd_pkg::in_item_t  sample_item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output ahrd_pkg::out_item_t      result_item
);

	ahrd_pkg::q_ctl_t q_ctl;
	ahrd_pkg::job_t   push_job;
	ahrd_pkg::job_t   head;
	logic             q_full;
	logic             q_nonempty;
	logic             pop;

	ahrd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.q_full       (q_full),
		.q_ctl        (q_ctl),
		.job          (push_job)
	);

	ahrd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_ctl    (q_ctl),
		.push_job (push_job),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head),
		.pop      (pop)
	);

	ahrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

`default_nettype wire
